// ===== rtl/core/ihc_pkg.sv =====
package ihc_pkg;

  // Verdict codes, in the order the checks are made.
  localparam logic [2:0] VERDICT_ACCEPT     = 3'd0;
  localparam logic [2:0] VERDICT_SHORT      = 3'd1;
  localparam logic [2:0] VERDICT_MISMATCH   = 3'd2;
  localparam logic [2:0] VERDICT_HDR_LONG   = 3'd3;
  localparam logic [2:0] VERDICT_BAD_CSUM   = 3'd4;
  localparam logic [2:0] VERDICT_FRAGMENTED = 3'd5;

  // Protocol classes.
  localparam logic [1:0] CLASS_ICMP  = 2'd0;
  localparam logic [1:0] CLASS_TCP   = 2'd1;
  localparam logic [1:0] CLASS_UDP   = 2'd2;
  localparam logic [1:0] CLASS_OTHER = 2'd3;

  // Protocol numbers that get a class of their own.
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Header word positions that carry fields of interest.
  localparam logic [4:0] WORD_TOTAL_LEN = 5'd1;
  localparam logic [4:0] WORD_FRAG      = 5'd3;
  localparam logic [4:0] WORD_PROTO     = 5'd4;
  localparam logic [4:0] WORD_SRC_HI    = 5'd6;
  localparam logic [4:0] WORD_SRC_LO    = 5'd7;

  localparam logic [15:0] MIN_FRAME_BYTES = 16'd20;
  localparam logic [15:0] DF_MASK         = 16'h4000;
  localparam logic [15:0] CSUM_GOOD       = 16'hFFFF;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;

  typedef struct packed {
    logic        start_req;
    logic [15:0] frame_length;
    logic [15:0] header_word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] payload_length;
    logic [5:0]  payload_offset;
    logic [31:0] source_address;
    logic [7:0]  protocol_number;
    logic [1:0]  proto_class;
    logic [2:0]  verdict;
  } result_t;

endpackage

// ===== rtl/core/ihc_step.sv =====
module ihc_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  ihc_pkg::in_item_t item,
  output logic              res_valid,
  output ihc_pkg::result_t  res
);
  import ihc_pkg::*;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = {1'b0, s[15:0]} + {16'b0, s[16]};
    return t[15:0];
  endfunction

  logic [4:0]  word_index, word_index_next;
  logic        verdict_done, verdict_done_next;
  logic [15:0] ones_sum, ones_sum_next;
  logic [3:0]  header_words, header_words_next;
  logic [15:0] ip_len, ip_len_next;
  logic [15:0] frame_len, frame_len_next;
  logic [15:0] frag_field, frag_field_next;
  logic [7:0]  proto_byte, proto_byte_next;
  logic [31:0] src_addr, src_addr_next;

  logic [2:0]  verdict;
  logic [4:0]  hw2;
  logic [4:0]  last_word;
  logic [5:0]  hbytes;
  logic        active;
  logic [15:0] w;

  always_comb begin
    word_index_next   = word_index;
    verdict_done_next = verdict_done;
    ones_sum_next     = ones_sum;
    header_words_next = header_words;
    ip_len_next       = ip_len;
    frame_len_next    = frame_len;
    frag_field_next   = frag_field;
    proto_byte_next   = proto_byte;
    src_addr_next     = src_addr;
    res_valid         = 1'b0;
    verdict           = VERDICT_ACCEPT;
    active            = 1'b1;
    w                 = item.header_word;

    if (item.start_req) begin
      word_index_next   = '0;
      verdict_done_next = 1'b0;
      ones_sum_next     = '0;
      ip_len_next       = '0;
      frag_field_next   = '0;
      proto_byte_next   = '0;
      src_addr_next     = '0;
      frame_len_next    = item.frame_length;
      header_words_next = w[11:8];
      if (item.frame_length < MIN_FRAME_BYTES) begin
        res_valid         = 1'b1;
        verdict           = VERDICT_SHORT;
        verdict_done_next = 1'b1;
        active            = 1'b0;
      end
    end else if (verdict_done) begin
      active = 1'b0;
    end

    hw2       = {header_words_next, 1'b0};
    last_word = (hw2 < 5'd8) ? 5'd7 : hw2 - 5'd1;
    hbytes    = {header_words_next, 2'b00};

    if (active) begin
      if (word_index_next < hw2) begin
        ones_sum_next = oc_add(ones_sum_next, w);
      end
      unique case (word_index_next)
        WORD_TOTAL_LEN: ip_len_next = w;
        WORD_FRAG:      frag_field_next = w;
        WORD_PROTO:     proto_byte_next = w[7:0];
        WORD_SRC_HI:    src_addr_next = {w, src_addr_next[15:0]};
        WORD_SRC_LO:    src_addr_next = {src_addr_next[31:16], w};
        default:        ;
      endcase

      priority if (word_index_next == WORD_TOTAL_LEN &&
                   frame_len_next < ip_len_next) begin
        res_valid = 1'b1;
        verdict   = VERDICT_MISMATCH;
      end else if (word_index_next == WORD_TOTAL_LEN &&
                   {10'b0, hbytes} > ip_len_next) begin
        res_valid = 1'b1;
        verdict   = VERDICT_HDR_LONG;
      end else if (word_index_next >= last_word) begin
        res_valid = 1'b1;
        if (ones_sum_next != CSUM_GOOD) begin
          verdict = VERDICT_BAD_CSUM;
        end else if ((frag_field_next & ~DF_MASK) != 16'h0000) begin
          verdict = VERDICT_FRAGMENTED;
        end else begin
          verdict = VERDICT_ACCEPT;
        end
      end else begin
        word_index_next = word_index_next + 5'd1;
      end

      if (res_valid) begin
        verdict_done_next = 1'b1;
      end
    end
  end

  // Result fields; a rejected datagram reports all of them but the verdict as zero.
  always_comb begin
    res         = '0;
    res.verdict = verdict;
    if (verdict == VERDICT_ACCEPT) begin
      priority if (proto_byte_next == PROTO_ICMP) begin
        res.proto_class = CLASS_ICMP;
      end else if (proto_byte_next == PROTO_TCP) begin
        res.proto_class = CLASS_TCP;
      end else if (proto_byte_next == PROTO_UDP) begin
        res.proto_class = CLASS_UDP;
      end else begin
        res.proto_class = CLASS_OTHER;
      end
      res.protocol_number = proto_byte_next;
      res.source_address  = src_addr_next;
      res.payload_offset  = hbytes;
      res.payload_length  = ip_len_next - {10'b0, hbytes};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index   <= '0;
      verdict_done <= 1'b1;
      ones_sum     <= '0;
      header_words <= '0;
      ip_len       <= '0;
      frame_len    <= '0;
      frag_field   <= '0;
      proto_byte   <= '0;
      src_addr     <= '0;
    end else if (go) begin
      word_index   <= word_index_next;
      verdict_done <= verdict_done_next;
      ones_sum     <= ones_sum_next;
      header_words <= header_words_next;
      ip_len       <= ip_len_next;
      frame_len    <= frame_len_next;
      frag_field   <= frag_field_next;
      proto_byte   <= proto_byte_next;
      src_addr     <= src_addr_next;
    end
  end

endmodule

// ===== rtl/core/ihc_out_reg.sv =====
module ihc_out_reg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  ihc_pkg::result_t                  res,
  output logic                              can_load,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ihc_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import ihc_pkg::*;

  result_t held;

  // The slot takes a new result when it is empty or drains this cycle.
  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      held <= res;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, held};

endmodule

// ===== rtl/core/ipv4_header_checker_top.sv =====
// IPv4 receive header checker. Header words enter one per transfer on the
// slave stream, big-endian, with the first word of each datagram flagged in
// s_tuser and the (saturated) frame length carried alongside every word; only
// the first word's length is used. For each datagram the block delivers one
// result transfer on the master stream holding the verdict of the first
// failing check (short frame, length mismatch, header too long, bad header
// checksum, fragmented; zero means accepted) together with protocol class,
// protocol number, source address, payload offset and payload length, all
// zero for a rejected datagram. Words after the verdict are dropped until
// the next start word, and a start word in the middle of a datagram abandons
// it. The block takes one word per clock cycle unless back pressure stalls it:
// each word is registered in the input register, then the per-word step logic
// updates the header state and, when a verdict is reached, loads the output
// register, from which the result is offered on the master side. A short
// frame is decided on its start word, a length error on the second word, and
// every other verdict on word max(2*IHL, 8) - 1. Back pressure on the master
// side holds the input register only while a result waits and the held word
// would produce another; only then does the slave side stall.
module ipv4_header_checker_top (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata fields, lowest bit up: frame_length[15:0], header_word[31:16].
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ihc_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser fields: start_req[0].
  input  logic                           s_tuser,
  // m_tdata fields, lowest bit up: verdict[2:0], proto_class[4:3],
  // protocol_number[12:5], source_address[44:13], payload_offset[50:45],
  // payload_length[66:51], zero fill[71:67].
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ihc_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ihc_pkg::*;

  in_item_t in_item;
  logic     in_valid;
  logic     go;
  logic     can_load;
  logic     res_valid;
  result_t  res;

  // A held word is processed unless its result would find the output
  // register still occupied.
  assign go       = in_valid && (can_load || !res_valid);
  assign s_tready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.start_req    <= s_tuser;
      in_item.frame_length <= s_tdata[15:0];
      in_item.header_word  <= s_tdata[31:16];
    end
  end

  ihc_step u_step (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .item      (in_item),
    .res_valid (res_valid),
    .res       (res)
  );

  ihc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (go && res_valid),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/core/ihc_checker.sv =====
module ihc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ihc_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ihc_pkg::*;

  result_t r;
  assign r = m_tdata[$bits(result_t)-1:0];

  // No result may come out of reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // A rejected datagram carries only its verdict.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.verdict != VERDICT_ACCEPT |->
      r.proto_class == 2'd0 && r.protocol_number == 8'd0 &&
      r.source_address == 32'd0 && r.payload_offset == 6'd0 &&
      r.payload_length == 16'd0 && m_tdata[OUT_DATA_W-1:$bits(result_t)] == '0)
    else $error("rejected datagram with nonzero fields");

  // An accepted datagram has a whole-word header and a class that matches.
  a_accept_sane: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.verdict == VERDICT_ACCEPT |->
      r.payload_offset != 6'd0 && r.payload_offset[1:0] == 2'b00 &&
      (r.protocol_number == PROTO_TCP) == (r.proto_class == CLASS_TCP) &&
      (r.protocol_number == PROTO_UDP) == (r.proto_class == CLASS_UDP) &&
      (r.protocol_number == PROTO_ICMP) == (r.proto_class == CLASS_ICMP))
    else $error("accepted datagram with inconsistent fields");

endmodule

bind ipv4_header_checker_top ihc_checker u_ihc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
